// ===== hw/rtl/ecr_pkg.sv =====
package ecr_pkg;

    localparam int W     = 32;
    localparam int LANES = 4;
    localparam int NFLD  = 10;
    localparam int MW    = W + 1;
    localparam int PW    = 2 * W;
    localparam int DOTW  = PW + 1;
    localparam int HIW   = DOTW - W;
    localparam int THW   = HIW + W;
    localparam int DLW   = W + MW;
    localparam int DHW   = HIW + MW;
    localparam int TW    = DOTW + W;
    localparam int CHW   = TW - 2 * W;
    localparam int NW    = TW + W + 1;
    localparam int DENW  = DOTW + MW;
    localparam int QW    = 34;
    localparam int REMW  = DENW + QW;
    localparam int MAGW  = QW + 1;
    localparam int DLTW  = QW + 3;
    localparam int SW    = 40;

    localparam int LANE_X1 = 0;
    localparam int LANE_Y1 = 1;
    localparam int LANE_X2 = 2;
    localparam int LANE_Y2 = 3;

    typedef struct packed {
        logic [LANES-1:0][W-1:0] pos;
        logic [LANES-1:0][W-1:0] vel;
        logic                    coinc;
        logic                    mzero;
        logic [LANES-1:0]        neg;
    } side_t;

    function automatic logic [W:0] sat_w(input logic [SW-1:0] v);
        logic [W-1:0] val;
        logic         flag;
        flag = !((&v[SW-1:W-1]) || !(|v[SW-1:W-1]));
        if (!flag) begin
            val = v[W-1:0];
        end else if (v[SW-1]) begin
            val = {1'b1, {(W-1){1'b0}}};
        end else begin
            val = {1'b0, {(W-1){1'b1}}};
        end
        return {flag, val};
    endfunction

endpackage

// ===== hw/rtl/ecr_front.sv =====
module ecr_front (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [ecr_pkg::NFLD*ecr_pkg::W-1:0]         in_data,
    output logic                                        out_valid,
    output ecr_pkg::side_t                              out_side,
    output logic [ecr_pkg::LANES-1:0][ecr_pkg::NW-1:0]  out_num,
    output logic [ecr_pkg::DENW-1:0]                    out_den
);
    import ecr_pkg::*;

    logic [6:0] valid_reg;

    logic [W-1:0] fld [NFLD];
    logic [W:0]   dif [4];
    logic [W:0]   ndif [4];
    logic [3:0][W-1:0] mag;
    logic [3:0]   sgn;
    side_t        side_s1;

    side_t             side1_reg;
    logic [3:0][W-1:0] mag1_reg;
    logic [3:0]        sgn1_reg;
    logic [W-1:0]      m1_1_reg, m2_1_reg;

    side_t             side2_reg;
    logic [PW-1:0]     pa2_reg, pb2_reg, sx2_reg, sy2_reg;
    logic [1:0][W-1:0] magd2_reg;
    logic [3:0]        sgn2_reg;
    logic [W-1:0]      m1_2_reg, m2_2_reg;
    logic [MW-1:0]     msum2_reg;

    logic [DOTW-1:0]   dot_s3, dist_s3;
    logic              dn_s3, na, nb;
    side_t             side_s3;
    side_t             side3_reg;
    logic [DOTW-1:0]   dot3_reg, dist3_reg;
    logic [1:0][W-1:0] magd3_reg;
    logic [W-1:0]      m1_3_reg, m2_3_reg;
    logic [MW-1:0]     msum3_reg;

    side_t               side4_reg;
    logic [1:0][PW-1:0]  tlo4_reg;
    logic [1:0][THW-1:0] thi4_reg;
    logic [DLW-1:0]      dlo4_reg;
    logic [DHW-1:0]      dhi4_reg;
    logic [W-1:0]        m1_4_reg, m2_4_reg;

    side_t              side5_reg;
    logic [1:0][TW-1:0] t5_reg;
    logic [DENW-1:0]    den5_reg;
    logic [W-1:0]       m1_5_reg, m2_5_reg;

    side_t                  side6_reg;
    logic [LANES-1:0][PW-1:0]   p0_6_reg, p1_6_reg;
    logic [LANES-1:0][CHW+W-1:0] p2_6_reg;
    logic [DENW-1:0]        den6_reg;

    side_t                    side7_reg;
    logic [LANES-1:0][NW-1:0] num7_reg;
    logic [DENW-1:0]          den7_reg;

    always_comb begin
        for (int i = 0; i < NFLD; i++) begin
            fld[i] = in_data[i*W +: W];
        end
        for (int k = 0; k < 4; k++) begin
            dif[k]  = {fld[k][W-1], fld[k]} - {fld[k+5][W-1], fld[k+5]};
            ndif[k] = (W+1)'(0) - dif[k];
            mag[k]  = dif[k][W] ? ndif[k][W-1:0] : dif[k][W-1:0];
            sgn[k]  = dif[k][W];
        end
        side_s1.pos[LANE_X1] = fld[0];
        side_s1.pos[LANE_Y1] = fld[1];
        side_s1.vel[LANE_X1] = fld[2];
        side_s1.vel[LANE_Y1] = fld[3];
        side_s1.pos[LANE_X2] = fld[5];
        side_s1.pos[LANE_Y2] = fld[6];
        side_s1.vel[LANE_X2] = fld[7];
        side_s1.vel[LANE_Y2] = fld[8];
        side_s1.coinc = (dif[0] == '0) && (dif[1] == '0);
        side_s1.mzero = (fld[4] == '0) && (fld[9] == '0);
        side_s1.neg   = '0;
    end

    always_comb begin
        na = sgn2_reg[2] ^ sgn2_reg[0];
        nb = sgn2_reg[3] ^ sgn2_reg[1];
        if (na == nb) begin
            dot_s3 = {1'b0, pa2_reg} + {1'b0, pb2_reg};
            dn_s3  = na;
        end else if (pa2_reg >= pb2_reg) begin
            dot_s3 = {1'b0, pa2_reg} - {1'b0, pb2_reg};
            dn_s3  = na;
        end else begin
            dot_s3 = {1'b0, pb2_reg} - {1'b0, pa2_reg};
            dn_s3  = nb;
        end
        if (dot_s3 == '0) begin
            dn_s3 = 1'b0;
        end
        dist_s3 = {1'b0, sx2_reg} + {1'b0, sy2_reg};
        side_s3 = side2_reg;
        side_s3.neg[LANE_X1] = dn_s3 ^ sgn2_reg[0];
        side_s3.neg[LANE_Y1] = dn_s3 ^ sgn2_reg[1];
        side_s3.neg[LANE_X2] = ~(dn_s3 ^ sgn2_reg[0]);
        side_s3.neg[LANE_Y2] = ~(dn_s3 ^ sgn2_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side_s1;
            mag1_reg  <= mag;
            sgn1_reg  <= sgn;
            m1_1_reg  <= fld[4];
            m2_1_reg  <= fld[9];

            side2_reg    <= side1_reg;
            pa2_reg      <= PW'(mag1_reg[2]) * PW'(mag1_reg[0]);
            pb2_reg      <= PW'(mag1_reg[3]) * PW'(mag1_reg[1]);
            sx2_reg      <= PW'(mag1_reg[0]) * PW'(mag1_reg[0]);
            sy2_reg      <= PW'(mag1_reg[1]) * PW'(mag1_reg[1]);
            magd2_reg[0] <= mag1_reg[0];
            magd2_reg[1] <= mag1_reg[1];
            sgn2_reg     <= sgn1_reg;
            m1_2_reg     <= m1_1_reg;
            m2_2_reg     <= m2_1_reg;
            msum2_reg    <= {1'b0, m1_1_reg} + {1'b0, m2_1_reg};

            side3_reg <= side_s3;
            dot3_reg  <= dot_s3;
            dist3_reg <= dist_s3;
            magd3_reg <= magd2_reg;
            m1_3_reg  <= m1_2_reg;
            m2_3_reg  <= m2_2_reg;
            msum3_reg <= msum2_reg;

            side4_reg <= side3_reg;
            for (int a = 0; a < 2; a++) begin
                tlo4_reg[a] <= PW'(dot3_reg[W-1:0]) * PW'(magd3_reg[a]);
                thi4_reg[a] <= THW'(dot3_reg[DOTW-1:W]) * THW'(magd3_reg[a]);
            end
            dlo4_reg <= DLW'(dist3_reg[W-1:0]) * DLW'(msum3_reg);
            dhi4_reg <= DHW'(dist3_reg[DOTW-1:W]) * DHW'(msum3_reg);
            m1_4_reg <= m1_3_reg;
            m2_4_reg <= m2_3_reg;

            side5_reg <= side4_reg;
            for (int a = 0; a < 2; a++) begin
                t5_reg[a] <= TW'(tlo4_reg[a]) + (TW'(thi4_reg[a]) << W);
            end
            den5_reg <= DENW'(dlo4_reg) + (DENW'(dhi4_reg) << W);
            m1_5_reg <= m1_4_reg;
            m2_5_reg <= m2_4_reg;

            side6_reg <= side5_reg;
            den6_reg  <= den5_reg;
            for (int k = 0; k < LANES; k++) begin
                p0_6_reg[k] <= PW'(t5_reg[k%2][W-1:0]) * PW'((k < 2) ? m2_5_reg : m1_5_reg);
                p1_6_reg[k] <= PW'(t5_reg[k%2][2*W-1:W]) *
                               PW'((k < 2) ? m2_5_reg : m1_5_reg);
                p2_6_reg[k] <= (CHW+W)'(t5_reg[k%2][TW-1:2*W]) *
                               (CHW+W)'((k < 2) ? m2_5_reg : m1_5_reg);
            end

            side7_reg <= side6_reg;
            den7_reg  <= den6_reg;
            for (int k = 0; k < LANES; k++) begin
                num7_reg[k] <= (NW'(p0_6_reg[k]) + (NW'(p1_6_reg[k]) << W) +
                                (NW'(p2_6_reg[k]) << (2 * W))) << 1;
            end
        end
    end

    assign out_valid = valid_reg[6];
    assign out_side  = side7_reg;
    assign out_num   = num7_reg;
    assign out_den   = den7_reg;

endmodule

// ===== hw/rtl/ecr_div.sv =====
module ecr_div (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  ecr_pkg::side_t                                in_side,
    input  logic [ecr_pkg::LANES-1:0][ecr_pkg::NW-1:0]    in_num,
    input  logic [ecr_pkg::DENW-1:0]                      in_den,
    output logic                                          out_valid,
    output ecr_pkg::side_t                                out_side,
    output logic [ecr_pkg::LANES-1:0][ecr_pkg::MAGW-1:0]  out_mag
);
    import ecr_pkg::*;

    logic [QW:0]                  valid_reg;
    side_t                        side_reg  [QW+1];
    logic [DENW-1:0]              den_reg   [QW+1];
    logic [LANES-1:0][REMW-1:0]   rem_reg   [QW+1];
    logic [LANES-1:0][QW-1:0]     q_reg     [QW+1];
    logic [LANES-1:0]             clamp_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            den_reg[0]  <= in_den;
            for (int k = 0; k < LANES; k++) begin
                rem_reg[0][k]   <= REMW'(in_num[k]);
                q_reg[0][k]     <= '0;
                clamp_reg[0][k] <= REMW'(in_num[k]) >= (REMW'(in_den) << QW);
            end
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int BIT = QW - 1 - s;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (en) begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s+1]  <= side_reg[s];
                den_reg[s+1]   <= den_reg[s];
                clamp_reg[s+1] <= clamp_reg[s];
                for (int k = 0; k < LANES; k++) begin
                    if (rem_reg[s][k] >= (REMW'(den_reg[s]) << BIT)) begin
                        rem_reg[s+1][k] <= rem_reg[s][k] - (REMW'(den_reg[s]) << BIT);
                        q_reg[s+1][k]   <= q_reg[s][k] | (QW'(1) << BIT);
                    end else begin
                        rem_reg[s+1][k] <= rem_reg[s][k];
                        q_reg[s+1][k]   <= q_reg[s][k];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            out_mag[k] = clamp_reg[QW][k] ? {1'b1, {QW{1'b0}}} : {1'b0, q_reg[QW][k]};
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

// ===== hw/rtl/ecr_back.sv =====
module ecr_back (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  ecr_pkg::side_t                                in_side,
    input  logic [ecr_pkg::LANES-1:0][ecr_pkg::MAGW-1:0]  in_mag,
    output logic                                          out_valid,
    output logic [ecr_pkg::LANES*2*ecr_pkg::W-1:0]        out_data,
    output logic [1:0]                                    out_user
);
    import ecr_pkg::*;

    logic                     valid1_reg, valid2_reg;
    side_t                    side1_reg;
    logic [LANES-1:0][W-1:0]  vel1_reg;
    logic                     sat1_reg;
    logic [LANES*2*W-1:0]     data2_reg;
    logic [1:0]               user2_reg;

    logic [LANES-1:0][W-1:0]  vel_s1;
    logic                     sat_s1;
    logic [DLTW-1:0]          dext, delta, vnew;
    logic [W:0]               sv;

    logic [LANES-1:0][W-1:0]  pos_s2;
    logic                     sat_s2;
    logic [SW-1:0]            vw, pw;
    logic [W:0]               sp;
    logic [LANES*2*W-1:0]     data_s2;
    logic [1:0]               user_s2;

    always_comb begin
        sat_s1 = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            dext  = in_side.mzero ? '0 : DLTW'(in_mag[k]);
            delta = in_side.neg[k] ? DLTW'(0) - dext : dext;
            vnew  = {{(DLTW-W){in_side.vel[k][W-1]}}, in_side.vel[k]} - delta;
            sv    = sat_w({{(SW-DLTW){vnew[DLTW-1]}}, vnew});
            vel_s1[k] = sv[W-1:0];
            sat_s1    = sat_s1 | sv[W];
        end
    end

    always_comb begin
        sat_s2 = sat1_reg;
        for (int k = 0; k < LANES; k++) begin
            vw = {{(SW-W){vel1_reg[k][W-1]}}, vel1_reg[k]};
            pw = {{(SW-W){side1_reg.pos[k][W-1]}}, side1_reg.pos[k]} + (vw << 5) - (vw << 1);
            sp = sat_w(pw);
            pos_s2[k] = sp[W-1:0];
            sat_s2    = sat_s2 | sp[W];
        end
        if (side1_reg.coinc) begin
            data_s2 = {side1_reg.vel[LANE_Y2], side1_reg.vel[LANE_X2],
                       side1_reg.pos[LANE_Y2], side1_reg.pos[LANE_X2],
                       side1_reg.vel[LANE_Y1], side1_reg.vel[LANE_X1],
                       side1_reg.pos[LANE_Y1], side1_reg.pos[LANE_X1]};
            user_s2 = 2'b01;
        end else begin
            data_s2 = {vel1_reg[LANE_Y2], vel1_reg[LANE_X2],
                       pos_s2[LANE_Y2], pos_s2[LANE_X2],
                       vel1_reg[LANE_Y1], vel1_reg[LANE_X1],
                       pos_s2[LANE_Y1], pos_s2[LANE_X1]};
            user_s2 = {sat_s2, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= in_side;
            vel1_reg  <= vel_s1;
            sat1_reg  <= sat_s1;
            data2_reg <= data_s2;
            user2_reg <= user_s2;
        end
    end

    assign out_valid = valid2_reg;
    assign out_data  = data2_reg;
    assign out_user  = user2_reg;

endmodule

// ===== hw/rtl/elastic_collision_resolver.sv =====
// Resolves one elastic collision of two particles in the plane per transfer.
// Slave channel: one pair per transfer; s_tdata carries both bodies' position,
// velocity and mass, signed/unsigned 32-bit fixed point, first body lowest.
// Master channel: one result per transfer; m_tdata carries the new positions
// and velocities, m_tuser the coincident and saturated flags.
// From the slave transfer to m_tvalid a pair passes the difference, dot
// product and wide multiply stages, the bit-per-stage quotient pipeline
// (one overflow check, 34 quotient bits), and the velocity update and
// position advance stages.
// Throughput is one pair per cycle; a new transfer is taken in every cycle
// in which the output stage is empty or being drained.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready on the first cycle after.
module elastic_collision_resolver (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass
    input  logic [ecr_pkg::NFLD*ecr_pkg::W-1:0]          s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
    // new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y
    output logic [ecr_pkg::LANES*2*ecr_pkg::W-1:0]       m_tdata,
    // coincident, saturated
    output logic [1:0]                                   m_tuser
);
    import ecr_pkg::*;

    logic                     en;
    logic                     f_valid, d_valid;
    side_t                    f_side, d_side;
    logic [LANES-1:0][NW-1:0] f_num;
    logic [DENW-1:0]          f_den;
    logic [LANES-1:0][MAGW-1:0] d_mag;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ecr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_num   (f_num),
        .out_den   (f_den)
    );

    ecr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_num    (f_num),
        .in_den    (f_den),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_mag   (d_mag)
    );

    ecr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_mag    (d_mag),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
